[src/spm_pkg.sv]
package spm_pkg;

    localparam int MAX_KNOTS_DEF = 16;

    typedef enum logic [1:0] {
        ACT_CLEAR  = 2'd0,
        ACT_APPEND = 2'd1,
        ACT_EVAL   = 2'd2,
        ACT_NONE   = 2'd3
    } t_action;

    typedef enum logic [1:0] {
        STAT_OK    = 2'd0,
        STAT_EMPTY = 2'd1,
        STAT_ORDER = 2'd2,
        STAT_FULL  = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        MUL_ADV_E,
        MUL_V0_E,
        MUL_DVE_E,
        MUL_V0_DIFF
    } t_mul_sel;

    typedef enum logic {
        DIV_DVE,
        DIV_ACC
    } t_div_sel;

    typedef enum logic [4:0] {
        S_IDLE,
        S_DISP,
        S_LOAD0,
        S_READ,
        S_SEG,
        S_CLAMP,
        S_MULA,
        S_DIVA,
        S_WAITA,
        S_MULB,
        S_MULC,
        S_INC,
        S_ADD,
        S_DIVB,
        S_WAITB,
        S_TAIL,
        S_TMUL,
        S_TINC,
        S_TADD,
        S_DONE
    } t_state;

    typedef struct packed {
        logic [1:0]         action;
        logic [31:0]        time_q16;
        logic [31:0]        speed_q16;
        logic signed [63:0] start_position;
    } t_in_item;

    typedef struct packed {
        logic [1:0]         status;
        logic signed [63:0] position;
        logic [31:0]        velocity;
        logic signed [31:0] acceleration;
        logic [4:0]         knots_held;
    } t_out_item;

    typedef struct packed {
        logic     latch_in;
        logic     do_clear;
        logic     do_append;
        logic     set_result;
        t_status  res_status;
        logic     load0;
        logic     advance;
        logic     seg_load;
        logic     clamp;
        logic     mul_en;
        t_mul_sel mul_sel;
        logic     div_start;
        t_div_sel div_sel;
        logic     dve_load;
        logic     term_load;
        logic     inc_load;
        logic     inc_tail;
        logic     pos_add;
        logic     vel_load;
        logic     acc_load;
        logic     tail_diff;
        logic     out_load;
    } t_cmd;

    typedef struct packed {
        t_action action;
        logic    empty;
        logic    full;
        logic    order_bad;
        logic    before_t1;
        logic    more_seg;
        logic    div_done;
        logic    out_busy;
    } t_stat;

endpackage

[src/spm_div.sv]
module spm_div (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [63:0] i_dividend,
    input  logic [31:0] i_divisor,
    output logic        o_done,
    output logic [63:0] o_quot
);

    // restoring divider, one quotient bit per cycle
    logic        r_busy, n_busy;
    logic        r_done, n_done;
    logic [5:0]  r_cnt, n_cnt;
    logic [63:0] r_q, n_q;
    logic [31:0] r_rem, n_rem;
    logic [31:0] r_dsr, n_dsr;
    logic [32:0] rem_sh;
    logic [33:0] diff;
    logic        ge;

    always_comb begin
        rem_sh = {r_rem, r_q[63]};
        diff   = {1'b0, rem_sh} - {2'b00, r_dsr};
        ge     = ~diff[33];
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_q    = r_q;
        n_rem  = r_rem;
        n_dsr  = r_dsr;
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = '0;
            n_q    = i_dividend;
            n_rem  = '0;
            n_dsr  = i_divisor;
        end else if (r_busy) begin
            n_rem = ge ? diff[31:0] : rem_sh[31:0];
            n_q   = {r_q[62:0], ge};
            n_cnt = r_cnt + 6'd1;
            if (r_cnt == 6'd63) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_q   <= n_q;
        r_rem <= n_rem;
        r_dsr <= n_dsr;
    end

    assign o_done = r_done;
    assign o_quot = r_q;

endmodule

[src/spm_dp.sv]
module spm_dp #(
    parameter int MAX_KNOTS = spm_pkg::MAX_KNOTS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  spm_pkg::t_cmd     i_cmd,
    output spm_pkg::t_stat    o_stat,
    input  spm_pkg::t_in_item i_in_data,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output spm_pkg::t_out_item o_out_data
);

    localparam int IDX_W = $clog2(MAX_KNOTS);
    localparam int CNT_W = $clog2(MAX_KNOTS + 1);

    logic [31:0] mem_t [MAX_KNOTS];
    logic [31:0] mem_v [MAX_KNOTS];

    logic [1:0]         r_action;
    logic [31:0]        r_tq, r_sq;
    logic signed [63:0] r_pos;
    logic [IDX_W-1:0]   r_idx;
    logic [CNT_W-1:0]   r_count;
    logic [31:0]        r_last_time;
    logic [31:0]        r_rd_t, r_rd_v;
    logic [31:0]        r_t0, r_v0, r_t1, r_v1;
    logic [31:0]        r_dt, r_adv, r_diff, r_e, r_dve;
    logic               r_neg;
    logic [63:0]        r_prod;
    logic [47:0]        r_term1;
    logic signed [63:0] r_inc;
    logic [31:0]        r_vel, r_acc;
    spm_pkg::t_status   r_status;
    logic               r_out_valid;
    spm_pkg::t_out_item r_out;

    logic [31:0]        mul_a, mul_b;
    logic [63:0]        div_dvd;
    logic               div_done;
    logic [63:0]        div_quot;
    logic signed [63:0] pos_sum;
    logic               pos_ovf;
    logic [63:0]        t2;
    logic [31:0]        amag_sat;

    spm_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (div_dvd),
        .i_divisor  (r_dt),
        .o_done     (div_done),
        .o_quot     (div_quot)
    );

    always_comb begin
        unique case (i_cmd.mul_sel)
            spm_pkg::MUL_ADV_E:   begin mul_a = r_adv; mul_b = r_e;    end
            spm_pkg::MUL_V0_E:    begin mul_a = r_v0;  mul_b = r_e;    end
            spm_pkg::MUL_DVE_E:   begin mul_a = r_dve; mul_b = r_e;    end
            spm_pkg::MUL_V0_DIFF: begin mul_a = r_v0;  mul_b = r_diff; end
            default:              begin mul_a = r_v0;  mul_b = r_diff; end
        endcase
        div_dvd = (i_cmd.div_sel == spm_pkg::DIV_DVE) ? r_prod : {16'd0, r_adv, 16'd0};
        t2      = {17'd0, r_prod[63:17]};
        pos_sum = r_pos + r_inc;
        pos_ovf = (r_pos[63] == r_inc[63]) && (pos_sum[63] != r_pos[63]);
        // slope magnitude clipped to the signed 32-bit range
        if (r_neg) begin
            amag_sat = (div_quot > 64'h8000_0000) ? 32'h8000_0000 : div_quot[31:0];
        end else begin
            amag_sat = (div_quot > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : div_quot[31:0];
        end
    end

    // knot store, one write and one registered read per cycle
    always_ff @(posedge i_clk) begin
        if (i_cmd.do_append) begin
            mem_t[r_count[IDX_W-1:0]] <= r_tq;
            mem_v[r_count[IDX_W-1:0]] <= r_sq;
        end
        r_rd_t <= mem_t[r_idx];
        r_rd_v <= mem_v[r_idx];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
            r_idx       <= '0;
        end else begin
            if (i_cmd.do_clear) r_count <= '0;
            else if (i_cmd.do_append) r_count <= r_count + CNT_W'(1);
            if (i_cmd.out_load) r_out_valid <= 1'b1;
            else if (i_out_ready) r_out_valid <= 1'b0;
            if (i_cmd.latch_in) r_idx <= '0;
            else if (i_cmd.load0) r_idx <= IDX_W'(1);
            else if (i_cmd.advance) r_idx <= r_idx + IDX_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.latch_in) begin
            r_action <= i_in_data.action;
            r_tq     <= i_in_data.time_q16;
            r_sq     <= i_in_data.speed_q16;
            r_pos    <= i_in_data.start_position;
            r_status <= spm_pkg::STAT_OK;
        end
        if (i_cmd.do_append) r_last_time <= r_tq;
        if (i_cmd.set_result) begin
            r_status <= i_cmd.res_status;
            r_pos    <= '0;
            r_vel    <= '0;
            r_acc    <= '0;
        end
        if (i_cmd.load0) begin
            r_t0 <= r_rd_t;
            r_v0 <= r_rd_v;
        end
        if (i_cmd.advance) begin
            r_t0 <= r_t1;
            r_v0 <= r_v1;
        end
        if (i_cmd.seg_load) begin
            r_t1   <= r_rd_t;
            r_v1   <= r_rd_v;
            r_dt   <= r_rd_t - r_t0;
            r_neg  <= r_rd_v < r_v0;
            r_adv  <= (r_rd_v < r_v0) ? (r_v0 - r_rd_v) : (r_rd_v - r_v0);
            r_diff <= r_tq - r_t0;
        end
        if (i_cmd.tail_diff) r_diff <= r_tq - r_t0;
        if (i_cmd.clamp) r_e <= (r_diff > r_dt) ? r_dt : r_diff;
        if (i_cmd.mul_en) r_prod <= 64'(mul_a) * 64'(mul_b);
        if (i_cmd.dve_load) r_dve <= div_quot[31:0];
        if (i_cmd.term_load) r_term1 <= r_prod[63:16];
        if (i_cmd.inc_load) begin
            if (i_cmd.inc_tail) r_inc <= {16'd0, r_prod[63:16]};
            else if (r_neg) r_inc <= {16'd0, r_term1} - t2;
            else r_inc <= {16'd0, r_term1} + t2;
        end
        if (i_cmd.pos_add) begin
            if (pos_ovf) r_pos <= r_pos[63] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
            else r_pos <= pos_sum;
        end
        if (i_cmd.vel_load) begin
            if (i_cmd.inc_tail) r_vel <= r_v0;
            else if (r_neg) r_vel <= r_v0 - r_dve;
            else r_vel <= r_v0 + r_dve;
        end
        if (i_cmd.acc_load) begin
            if (i_cmd.inc_tail) r_acc <= '0;
            else r_acc <= r_neg ? (32'd0 - amag_sat) : amag_sat;
        end
        if (i_cmd.out_load) begin
            r_out.status       <= r_status;
            r_out.position     <= r_pos;
            r_out.velocity     <= r_vel;
            r_out.acceleration <= r_acc;
            r_out.knots_held   <= 5'(r_count);
        end
    end

    always_comb begin
        o_stat.action    = spm_pkg::t_action'(r_action);
        o_stat.empty     = (r_count == '0);
        o_stat.full      = (r_count == CNT_W'(MAX_KNOTS));
        o_stat.order_bad = (r_count == '0) ? (r_tq != 32'd0) : (r_tq <= r_last_time);
        o_stat.before_t1 = r_tq < r_t1;
        o_stat.more_seg  = (CNT_W'(r_idx) + CNT_W'(1)) < r_count;
        o_stat.div_done  = div_done;
        // output register can take a new result if empty or draining this cycle
        o_stat.out_busy  = r_out_valid && !i_out_ready;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

[src/spm_ctrl.sv]
module spm_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  spm_pkg::t_stat i_stat,
    output spm_pkg::t_cmd  o_cmd
);

    spm_pkg::t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= spm_pkg::S_IDLE;
        else r_state <= n_state;
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            spm_pkg::S_IDLE:  if (i_in_valid) n_state = spm_pkg::S_DISP;
            spm_pkg::S_DISP: begin
                if (i_stat.action == spm_pkg::ACT_EVAL && !i_stat.empty)
                    n_state = spm_pkg::S_LOAD0;
                else
                    n_state = spm_pkg::S_DONE;
            end
            spm_pkg::S_LOAD0: n_state = i_stat.more_seg ? spm_pkg::S_READ : spm_pkg::S_TAIL;
            spm_pkg::S_READ:  n_state = spm_pkg::S_SEG;
            spm_pkg::S_SEG:   n_state = spm_pkg::S_CLAMP;
            spm_pkg::S_CLAMP: n_state = spm_pkg::S_MULA;
            spm_pkg::S_MULA:  n_state = spm_pkg::S_DIVA;
            spm_pkg::S_DIVA:  n_state = spm_pkg::S_WAITA;
            spm_pkg::S_WAITA: if (i_stat.div_done) n_state = spm_pkg::S_MULB;
            spm_pkg::S_MULB:  n_state = spm_pkg::S_MULC;
            spm_pkg::S_MULC:  n_state = spm_pkg::S_INC;
            spm_pkg::S_INC:   n_state = spm_pkg::S_ADD;
            spm_pkg::S_ADD: begin
                priority if (i_stat.before_t1) n_state = spm_pkg::S_DIVB;
                else if (i_stat.more_seg) n_state = spm_pkg::S_READ;
                else n_state = spm_pkg::S_TAIL;
            end
            spm_pkg::S_DIVB:  n_state = spm_pkg::S_WAITB;
            spm_pkg::S_WAITB: if (i_stat.div_done) n_state = spm_pkg::S_DONE;
            spm_pkg::S_TAIL:  n_state = spm_pkg::S_TMUL;
            spm_pkg::S_TMUL:  n_state = spm_pkg::S_TINC;
            spm_pkg::S_TINC:  n_state = spm_pkg::S_TADD;
            spm_pkg::S_TADD:  n_state = spm_pkg::S_DONE;
            spm_pkg::S_DONE:  if (!i_stat.out_busy) n_state = spm_pkg::S_IDLE;
            default:          n_state = spm_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd          = '0;
        o_cmd.mul_sel  = spm_pkg::MUL_ADV_E;
        o_cmd.div_sel  = spm_pkg::DIV_DVE;
        o_cmd.res_status = spm_pkg::STAT_OK;
        o_in_ready     = (r_state == spm_pkg::S_IDLE);
        unique case (r_state)
            spm_pkg::S_IDLE: o_cmd.latch_in = i_in_valid && o_in_ready;
            spm_pkg::S_DISP: begin
                unique case (i_stat.action)
                    spm_pkg::ACT_CLEAR: begin
                        o_cmd.do_clear   = 1'b1;
                        o_cmd.set_result = 1'b1;
                    end
                    spm_pkg::ACT_APPEND: begin
                        o_cmd.set_result = 1'b1;
                        priority if (i_stat.full) o_cmd.res_status = spm_pkg::STAT_FULL;
                        else if (i_stat.order_bad) o_cmd.res_status = spm_pkg::STAT_ORDER;
                        else o_cmd.do_append = 1'b1;
                    end
                    spm_pkg::ACT_EVAL: begin
                        if (i_stat.empty) begin
                            o_cmd.set_result = 1'b1;
                            o_cmd.res_status = spm_pkg::STAT_EMPTY;
                        end
                    end
                    default: o_cmd.set_result = 1'b1;
                endcase
            end
            spm_pkg::S_LOAD0: o_cmd.load0 = 1'b1;
            spm_pkg::S_SEG:   o_cmd.seg_load = 1'b1;
            spm_pkg::S_CLAMP: o_cmd.clamp = 1'b1;
            spm_pkg::S_MULA: begin
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sel = spm_pkg::MUL_ADV_E;
            end
            spm_pkg::S_DIVA: begin
                o_cmd.div_start = 1'b1;
                o_cmd.div_sel   = spm_pkg::DIV_DVE;
            end
            spm_pkg::S_WAITA: o_cmd.dve_load = i_stat.div_done;
            spm_pkg::S_MULB: begin
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sel = spm_pkg::MUL_V0_E;
            end
            spm_pkg::S_MULC: begin
                o_cmd.term_load = 1'b1;
                o_cmd.mul_en    = 1'b1;
                o_cmd.mul_sel   = spm_pkg::MUL_DVE_E;
            end
            spm_pkg::S_INC: o_cmd.inc_load = 1'b1;
            spm_pkg::S_ADD: begin
                o_cmd.pos_add = 1'b1;
                o_cmd.advance = !i_stat.before_t1;
            end
            spm_pkg::S_DIVB: begin
                o_cmd.div_start = 1'b1;
                o_cmd.div_sel   = spm_pkg::DIV_ACC;
                o_cmd.vel_load  = 1'b1;
            end
            spm_pkg::S_WAITB: o_cmd.acc_load = i_stat.div_done;
            spm_pkg::S_TAIL:  o_cmd.tail_diff = 1'b1;
            spm_pkg::S_TMUL: begin
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sel = spm_pkg::MUL_V0_DIFF;
            end
            spm_pkg::S_TINC: begin
                o_cmd.inc_load = 1'b1;
                o_cmd.inc_tail = 1'b1;
                o_cmd.vel_load = 1'b1;
                o_cmd.acc_load = 1'b1;
            end
            spm_pkg::S_TADD: o_cmd.pos_add = 1'b1;
            spm_pkg::S_DONE: o_cmd.out_load = !i_stat.out_busy;
            default: o_cmd.latch_in = 1'b0;
        endcase
    end

endmodule

[src/speed_profile_motion_evaluator.sv]
// Clear, append, empty evaluate and unused action 3 go from dispatch to the result state.
// Evaluate walks each segment with a 64-step serial divide, then runs tail steps when the
// query is at or past the last knot, or a second divide when it lands inside a segment.
// One item at a time: the next input is taken in the cycle after the result is registered;
// a waiting result holds the block in its final state, not the input side.
// Reset (i_rst_n low, synchronous): empties the knot table and the output register.
module speed_profile_motion_evaluator #(
    parameter int MAX_KNOTS = spm_pkg::MAX_KNOTS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  spm_pkg::t_in_item   i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output spm_pkg::t_out_item  o_out_data
);

    // Controller sequences the per-segment walk; datapath holds knots,
    // one shared multiplier and the serial divider.
    spm_pkg::t_cmd  cmd;
    spm_pkg::t_stat stat;

    spm_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    spm_dp #(
        .MAX_KNOTS (MAX_KNOTS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

endmodule
